// ===== hdl/ple_pkg.sv =====
// ---------------------------------------------------------------------------
// ple_pkg
// Shared codes and controller/datapath command and status words for the
// positional list engine.
// ---------------------------------------------------------------------------
package ple_pkg;

   localparam int CAPACITY_DEFAULT = 16;

   typedef enum logic [2:0] {
      CMD_INS_FIRST = 3'd0,
      CMD_INS_LAST  = 3'd1,
      CMD_INS_AT    = 3'd2,
      CMD_DEL_FIRST = 3'd3,
      CMD_DEL_LAST  = 3'd4,
      CMD_DEL_AT    = 3'd5,
      CMD_SEARCH    = 3'd6,
      CMD_DUMP      = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_BADPOS = 3'd1,
      ST_BOUNDS = 3'd2,
      ST_EMPTY  = 3'd3,
      ST_FULL   = 3'd4
   } status_type;

   typedef struct packed {
      logic latch;
      logic load;
      logic rd_en;
      logic commit;
      logic reply;
   } ctl_type;

   typedef struct packed {
      logic scan;
      logic commit;
      logic dump;
      logic last;
   } stat_type;

endpackage

// ===== hdl/ple_ctrl.sv =====
// ---------------------------------------------------------------------------
// ple_ctrl
// Command sequencer: decode, scan of the entry memory, drain of the read
// pipeline, commit of the list update and the single-word reply.
// ---------------------------------------------------------------------------
module ple_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  ple_pkg::stat_type  stat,
   output ple_pkg::ctl_type   ctl
);
   import ple_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECODE = 6'b000010,
      S_SCAN   = 6'b000100,
      S_DRAIN  = 6'b001000,
      S_COMMIT = 6'b010000,
      S_REPLY  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            ctl.load = 1'b1;
            if (stat.scan) begin
               state_in = S_SCAN;
            end else if (stat.commit) begin
               state_in = S_COMMIT;
            end else begin
               state_in = S_REPLY;
            end
         end
         S_SCAN: begin
            ctl.rd_en = 1'b1;
            if (stat.last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (stat.commit) begin
               state_in = S_COMMIT;
            end else if (stat.dump) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_REPLY;
            end
         end
         S_COMMIT: begin
            ctl.commit = 1'b1;
            state_in   = S_REPLY;
         end
         S_REPLY: begin
            ctl.reply = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== hdl/ple_dpath.sv =====
// ---------------------------------------------------------------------------
// ple_dpath
// Entry memory, fill count, scan pointer, command decode and result
// registers of the positional list engine.
// ---------------------------------------------------------------------------
module ple_dpath #(
   parameter int CAPACITY = ple_pkg::CAPACITY_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  ple_pkg::ctl_type   ctl,
   output ple_pkg::stat_type  stat,
   input  logic [2:0]         req_cmd,
   input  logic signed [31:0] req_data_value,
   input  logic [7:0]         req_position,
   output logic               rsp_strobe,
   output logic [2:0]         rsp_status,
   output logic               rsp_found,
   output logic signed [31:0] rsp_item_value,
   output logic [4:0]         rsp_entry_count,
   output logic               rsp_last
);
   import ple_pkg::*;

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int MW = ((CW > 8) ? CW : 8) + 1;
   localparam int EW = CW + 5;

   cmd_type          cmd_ff;
   logic [31:0]      val_ff;
   logic [7:0]       pos_ff;
   logic [CW-1:0]    fill_ff;
   logic [IW-1:0]    ptr_ff;
   logic [IW-1:0]    end_ff;
   logic [IW-1:0]    idx_ff;
   logic             up_ff;
   status_type       status_ff;
   logic             found_ff;
   logic [31:0]      rd_data_ff;
   logic [IW-1:0]    rd_addr_ff;
   logic             rd_vld_ff;
   logic [31:0]      mem [CAPACITY];

   logic             rsp_strobe_ff;
   logic [2:0]       rsp_status_ff;
   logic             rsp_found_ff;
   logic [31:0]      rsp_item_ff;
   logic [4:0]       rsp_count_ff;
   logic             rsp_last_ff;

   logic [MW-1:0]    fill_x;
   logic [MW-1:0]    pos_x;
   logic [MW-1:0]    idx_x;
   logic [MW-1:0]    start_x;
   logic [MW-1:0]    end_x;
   logic             full;
   logic             empty;
   logic             ins_ok;
   logic             del_ok;
   logic             scan_c;
   logic             up_c;
   status_type       status_c;
   logic             ins_cmd;
   logic             wr_en;
   logic [IW-1:0]    wr_addr;
   logic [31:0]      wr_data;
   logic             emit_dump;
   logic             dump_last;
   logic [EW-1:0]    fill_w;

   assign fill_x = MW'(fill_ff);
   assign pos_x  = MW'(pos_ff);
   assign full   = (fill_x >= MW'(CAPACITY));
   assign empty  = (fill_x == '0);

   always_comb begin
      status_c = ST_OK;
      ins_ok   = 1'b0;
      del_ok   = 1'b0;
      idx_x    = '0;
      scan_c   = 1'b0;
      up_c     = 1'b1;
      start_x  = '0;
      end_x    = '0;
      case (cmd_ff)
         CMD_INS_FIRST: begin
            if (full) status_c = ST_FULL;
            else ins_ok = 1'b1;
         end
         CMD_INS_LAST: begin
            if (full) begin
               status_c = ST_FULL;
            end else begin
               ins_ok = 1'b1;
               idx_x  = fill_x;
            end
         end
         CMD_INS_AT: begin
            if (pos_x == '0) begin
               status_c = ST_BADPOS;
            end else if (full) begin
               status_c = ST_FULL;
            end else if (pos_x > fill_x + MW'(1)) begin
               status_c = ST_BOUNDS;
            end else begin
               ins_ok = 1'b1;
               idx_x  = pos_x - MW'(1);
            end
         end
         CMD_DEL_FIRST: begin
            if (empty) status_c = ST_EMPTY;
            else del_ok = 1'b1;
         end
         CMD_DEL_LAST: begin
            if (empty) begin
               status_c = ST_EMPTY;
            end else begin
               del_ok = 1'b1;
               idx_x  = fill_x - MW'(1);
            end
         end
         CMD_DEL_AT: begin
            if (pos_x == '0) begin
               status_c = ST_BADPOS;
            end else if (empty) begin
               status_c = ST_EMPTY;
            end else if (pos_x > fill_x) begin
               status_c = ST_BOUNDS;
            end else begin
               del_ok = 1'b1;
               idx_x  = pos_x - MW'(1);
            end
         end
         CMD_SEARCH: begin
            if (!empty) begin
               scan_c = 1'b1;
               end_x  = fill_x - MW'(1);
            end
         end
         CMD_DUMP: begin
            if (empty) begin
               status_c = ST_EMPTY;
            end else begin
               scan_c = 1'b1;
               end_x  = fill_x - MW'(1);
            end
         end
         default: begin
            status_c = ST_OK;
         end
      endcase
      if (ins_ok && (idx_x < fill_x)) begin
         scan_c  = 1'b1;
         up_c    = 1'b0;
         start_x = fill_x - MW'(1);
         end_x   = idx_x;
      end
      if (del_ok && ((idx_x + MW'(1)) < fill_x)) begin
         scan_c  = 1'b1;
         up_c    = 1'b1;
         start_x = idx_x + MW'(1);
         end_x   = fill_x - MW'(1);
      end
   end

   assign stat.scan   = scan_c;
   assign stat.commit = ins_ok | del_ok;
   assign stat.dump   = (cmd_ff == CMD_DUMP);
   assign stat.last   = (ptr_ff == end_ff);

   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         cmd_ff <= cmd_type'(req_cmd);
         val_ff <= req_data_value;
         pos_ff <= req_position;
      end
      if (ctl.load) begin
         ptr_ff    <= IW'(start_x);
         end_ff    <= IW'(end_x);
         idx_ff    <= IW'(idx_x);
         up_ff     <= up_c;
         status_ff <= status_c;
         found_ff  <= 1'b0;
      end else if (ctl.rd_en) begin
         ptr_ff <= up_ff ? ptr_ff + IW'(1) : ptr_ff - IW'(1);
      end
      if (rd_vld_ff && (cmd_ff == CMD_SEARCH) && (rd_data_ff == val_ff)) begin
         found_ff <= 1'b1;
      end
   end

   assign ins_cmd = (cmd_ff == CMD_INS_FIRST) || (cmd_ff == CMD_INS_LAST) ||
                    (cmd_ff == CMD_INS_AT);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rd_addr_ff;
      wr_data = rd_data_ff;
      if (ctl.commit) begin
         wr_en   = ins_cmd;
         wr_addr = idx_ff;
         wr_data = val_ff;
      end else if (rd_vld_ff && (cmd_ff != CMD_SEARCH) && (cmd_ff != CMD_DUMP)) begin
         wr_en   = 1'b1;
         wr_addr = ins_cmd ? rd_addr_ff + IW'(1) : rd_addr_ff - IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[ptr_ff];
         rd_addr_ff <= ptr_ff;
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rd_vld_ff     <= ctl.rd_en;
         rsp_strobe_ff <= ctl.reply | emit_dump;
         if (ctl.commit) begin
            fill_ff <= ins_cmd ? fill_ff + CW'(1) : fill_ff - CW'(1);
         end
      end
   end

   assign emit_dump = rd_vld_ff && (cmd_ff == CMD_DUMP);
   assign dump_last = (CW'(rd_addr_ff) == (fill_ff - CW'(1)));
   assign fill_w    = EW'(fill_ff);

   always_ff @(posedge clock) begin
      rsp_count_ff <= fill_w[4:0];
      if (emit_dump) begin
         rsp_status_ff <= ST_OK;
         rsp_found_ff  <= 1'b0;
         rsp_item_ff   <= rd_data_ff;
         rsp_last_ff   <= dump_last;
      end else begin
         rsp_status_ff <= status_ff;
         rsp_found_ff  <= found_ff;
         rsp_item_ff   <= '0;
         rsp_last_ff   <= 1'b1;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_item_value  = rsp_item_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(CAPACITY))
      else $error("fill count above capacity");

   a_commit_no_shift: assert property (@(posedge clock) disable iff (reset)
      ctl.commit |-> !rd_vld_ff)
      else $error("commit overlaps a shift write");

   a_reply_no_dump: assert property (@(posedge clock) disable iff (reset)
      ctl.reply |-> !emit_dump)
      else $error("reply collides with a dump word");

   a_read_follows_enable: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> $past(ctl.rd_en))
      else $error("read data valid without a read");

endmodule

// ===== hdl/positional_list_engine_top.sv =====
// ---------------------------------------------------------------------------
// positional_list_engine_top
// Bounded ordered list of signed 32-bit words with positional insert and
// delete, search and dump.
//
// A command word is taken at a clock edge with start high and busy low.
// busy stays high until the command is finished. Results appear on the rsp_
// ports for one cycle, marked by rsp_strobe; the receiver cannot stall and
// the block never waits on it. Every command gives one word with rsp_last
// set, except dump, which gives one word per entry in order (one word per
// cycle) with rsp_last on the final one, or a single empty word.
// Accepted inserts and deletes scan the k entries that move; search and
// dump scan all n entries of the list. Refused commands, commands that move
// nothing and commands on an empty list skip the scan. The scan of the entry
// memory reads one entry per cycle through a registered read. The result word
// is registered and follows in the cycle after the cycle that produces it.
// Reset clears the fill count and the sequencer; the entry memory is not
// cleared, and entries past the fill count are never read.
// ---------------------------------------------------------------------------
module positional_list_engine_top #(
   parameter int CAPACITY = ple_pkg::CAPACITY_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_cmd,
   input  logic signed [31:0] req_data_value,
   input  logic [7:0]         req_position,
   output logic               rsp_strobe,
   output logic [2:0]         rsp_status,
   output logic               rsp_found,
   output logic signed [31:0] rsp_item_value,
   output logic [4:0]         rsp_entry_count,
   output logic               rsp_last
);
   import ple_pkg::*;

   ctl_type  ctl;
   stat_type stat;

   ple_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .ctl   (ctl)
   );

   ple_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .stat            (stat),
      .req_cmd         (req_cmd),
      .req_data_value  (req_data_value),
      .req_position    (req_position),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_item_value  (rsp_item_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_last        (rsp_last)
   );

endmodule
